// ===== hw/rtl/pcx_rle_decode_palette_macros.svh =====
// assertion macros for the pcx run-length decoder
`ifndef PCX_RLE_DECODE_PALETTE_MACROS_SVH
`define PCX_RLE_DECODE_PALETTE_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define PCXD_ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("pcxd assertion failed");

// condition must hold in the cycle after the trigger
`define PCXD_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("pcxd assertion failed");

`endif

// ===== hw/rtl/pcxd_pkg.sv =====
// shared types and constants of the pcx run-length decoder
package pcxd_pkg;

  localparam int MAX_DIM = 4096;
  localparam int PALETTE_ENTRIES = 256;

  localparam int DIM_W = 13;
  localparam int COL_W = 14;
  localparam int RUN_W = 6;
  localparam int IDX_W = 8;
  localparam int COLOR_W = 24;
  localparam int POS_W = 12;

  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_PALETTE = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LINE_BYTES = 2'd2;

  localparam logic [1:0] COUNT_MARK = 2'b11;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [COL_W-1:0] line_bytes;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             last;
  } pix_req_t;

  typedef struct packed {
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   column;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   index;
    logic               last;
  } pix_out_t;

endpackage

// ===== hw/rtl/pcxd_ram.sv =====
// generic single-write, single-read ram with registered read data
module pcxd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pcxd_seq.sv =====
// run sequencer: decodes count and literal bytes and steps columns and rows
module pcxd_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic [1:0]                cmd,
  input  logic [7:0]                data_byte,
  input  pcxd_pkg::cfg_t            cfg,
  input  logic                      space,
  output logic                      s_tready,
  output logic                      busy,
  output logic                      req_valid,
  output pcxd_pkg::pix_req_t        req
);

  logic [pcxd_pkg::COL_W-1:0] column;
  logic [pcxd_pkg::DIM_W-1:0] row;
  logic                       awaiting;
  logic [pcxd_pkg::RUN_W-1:0] pending;
  logic [pcxd_pkg::RUN_W-1:0] remain;
  logic [pcxd_pkg::IDX_W-1:0] value;

  logic [pcxd_pkg::DIM_W-1:0] width_c;
  logic [pcxd_pkg::DIM_W-1:0] height_c;
  logic                       accept;
  logic                       is_data;
  logic                       is_count;
  logic                       step_go;
  logic [pcxd_pkg::RUN_W-1:0] step_run;
  logic [pcxd_pkg::IDX_W-1:0] step_val;
  logic                       emit;
  logic [pcxd_pkg::COL_W-1:0] col_inc;
  logic                       line_end;
  logic                       more;
  logic [pcxd_pkg::COL_W-1:0] column_next;
  logic [pcxd_pkg::DIM_W-1:0] row_next;

  assign width_c = (cfg.width > pcxd_pkg::DIM_W'(pcxd_pkg::MAX_DIM)) ?
                   pcxd_pkg::DIM_W'(pcxd_pkg::MAX_DIM) : cfg.width;
  assign height_c = (cfg.height > pcxd_pkg::DIM_W'(pcxd_pkg::MAX_DIM)) ?
                    pcxd_pkg::DIM_W'(pcxd_pkg::MAX_DIM) : cfg.height;

  assign s_tready = !busy && space;
  assign accept = s_tvalid && s_tready;
  assign is_data = accept && (cmd == pcxd_pkg::CMD_DATA) && (row < height_c);
  assign is_count = (data_byte[7:6] == pcxd_pkg::COUNT_MARK);

  always_comb begin
    if (busy) begin
      step_go = space;
      step_run = remain;
      step_val = value;
    end else begin
      step_go = is_data && (awaiting ? (pending != '0) : !is_count);
      step_run = awaiting ? pending : pcxd_pkg::RUN_W'(1);
      step_val = data_byte;
    end
  end

  // one decoded byte per step
  assign emit = {1'b0, column} < {2'b0, width_c};
  assign col_inc = column + pcxd_pkg::COL_W'(1);
  assign line_end = col_inc >= cfg.line_bytes;
  assign more = !line_end && (step_run > pcxd_pkg::RUN_W'(1));
  assign column_next = line_end ? '0 : col_inc;
  assign row_next = line_end ? row + pcxd_pkg::DIM_W'(1) : row;

  assign req_valid = step_go && emit;
  assign req.index = step_val;
  assign req.column = column[pcxd_pkg::POS_W-1:0];
  assign req.row = row[pcxd_pkg::POS_W-1:0];
  assign req.last = !more || ({1'b0, col_inc} >= {2'b0, width_c});

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row <= '0;
      awaiting <= 1'b0;
      pending <= '0;
      remain <= '0;
      busy <= 1'b0;
      value <= '0;
    end else begin
      if (accept && (cmd == pcxd_pkg::CMD_START)) begin
        column <= '0;
        row <= '0;
        awaiting <= 1'b0;
        pending <= '0;
      end
      if (is_data) begin
        if (awaiting) begin
          awaiting <= 1'b0;
        end else if (is_count) begin
          pending <= data_byte[pcxd_pkg::RUN_W-1:0];
          awaiting <= 1'b1;
        end
      end
      if (step_go) begin
        column <= column_next;
        row <= row_next;
        busy <= more;
        remain <= step_run - pcxd_pkg::RUN_W'(1);
        value <= step_val;
      end
    end
  end

endmodule

// ===== hw/rtl/pcxd_obuf.sv =====
// two-entry output buffer between the palette read and the pixel stream
module pcxd_obuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pcxd_pkg::pix_out_t   push_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output pcxd_pkg::pix_out_t   head,
  output logic                 pop,
  output logic [1:0]           count
);

  pcxd_pkg::pix_out_t slots [2];
  logic               wptr;
  logic               rptr;

  assign m_tvalid = (count != 2'd0);
  assign pop = m_tvalid && m_tready;
  assign head = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hw/rtl/pcx_rle_decode_palette.sv =====
// top level of the pcx run-length decoder with palette lookup
//
// input stream s_*: one transaction per command; s_tuser is the command
// (data byte, palette write, start of image). a data byte is either a
// literal pixel index or a run count whose value follows in the next byte.
// output stream m_*: one transaction per visible pixel with its palette
// color and position; m_tlast marks the last pixel caused by one input.
// registers image_width, image_height and line_bytes sit on apb byte addresses
// 0, 4 and 8 and must be written only while the stream is idle (not enforced).
// each decoded byte takes one step of the run sequencer, so a literal costs
// one step and a run of n up to n steps; s_tready stays low for the rest of a run.
// a pixel goes from its step through the registered palette ram read and
// then the output buffer before it appears on m_tdata.
// when m_tready is low the two-entry output buffer fills and the sequencer
// and input stall; nothing is lost.
// reset clears position, run state and buffers; the palette ram keeps its
// contents and entries are undefined until written.
`include "pcx_rle_decode_palette_macros.svh"

module pcx_rle_decode_palette (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // data_byte[7:0], palette_index[15:8], palette_color[39:16]
  input  logic [39:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_index[7:0], pixel_color[31:8], column[43:32], row[55:44]
  output logic [55:0] m_tdata,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pcxd_pkg::cfg_t     cfg;
  logic               cfg_we;
  logic               space;
  logic               busy;
  logic               req_valid;
  pcxd_pkg::pix_req_t req;
  logic               inflight;
  pcxd_pkg::pix_req_t req_q;
  logic [23:0]        rd_color;
  pcxd_pkg::pix_out_t push_data;
  pcxd_pkg::pix_out_t head;
  logic               pop;
  logic [1:0]         count;
  logic [2:0]         total;
  logic               pal_we;

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width <= pcxd_pkg::DIM_W'(1);
      cfg.height <= pcxd_pkg::DIM_W'(1);
      cfg.line_bytes <= pcxd_pkg::COL_W'(2);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        pcxd_pkg::REG_WIDTH:      cfg.width <= pwdata[pcxd_pkg::DIM_W-1:0];
        pcxd_pkg::REG_HEIGHT:     cfg.height <= pwdata[pcxd_pkg::DIM_W-1:0];
        pcxd_pkg::REG_LINE_BYTES: cfg.line_bytes <= pwdata[pcxd_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pcxd_pkg::REG_WIDTH:      prdata = {19'd0, cfg.width};
      pcxd_pkg::REG_HEIGHT:     prdata = {19'd0, cfg.height};
      pcxd_pkg::REG_LINE_BYTES: prdata = {18'd0, cfg.line_bytes};
      default:                  prdata = '0;
    endcase
  end

  // room for one more step, counting the read in flight
  assign total = {1'b0, count} + {2'b0, inflight};
  assign space = (total < 3'd2) || ((total == 3'd2) && pop);

  pcxd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .cmd       (s_tuser),
    .data_byte (s_tdata[7:0]),
    .cfg       (cfg),
    .space     (space),
    .s_tready  (s_tready),
    .busy      (busy),
    .req_valid (req_valid),
    .req       (req)
  );

  assign pal_we = s_tvalid && s_tready && (s_tuser == pcxd_pkg::CMD_PALETTE);

  pcxd_ram #(
    .WIDTH (pcxd_pkg::COLOR_W),
    .DEPTH (pcxd_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (s_tdata[15:8]),
    .wdata (s_tdata[39:16]),
    .re    (req_valid),
    .raddr (req.index),
    .rdata (rd_color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 1'b0;
    end else begin
      inflight <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      req_q <= req;
    end
  end

  assign push_data.row = req_q.row;
  assign push_data.column = req_q.column;
  assign push_data.color = rd_color;
  assign push_data.index = req_q.index;
  assign push_data.last = req_q.last;

  pcxd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (inflight),
    .push_data (push_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .head      (head),
    .pop       (pop),
    .count     (count)
  );

  assign m_tdata = {head.row, head.column, head.color, head.index};
  assign m_tlast = head.last;

  `PCXD_ASSERT_SAME(a_no_overfill, clk, rst, 1'b1, total <= 3'd2)
  `PCXD_ASSERT_SAME(a_no_rw_clash, clk, rst, pal_we, !req_valid)
  `PCXD_ASSERT_NEXT(a_read_delivers, clk, rst, inflight, m_tvalid)
  `PCXD_ASSERT_SAME(a_busy_stalls, clk, rst, busy, !s_tready)

endmodule
